[hdl/spca_pkg.sv]
// ----------------------------------------------------------------------------
// spca_pkg
// Shared types and constants of the staging page chunk allocator.
// ----------------------------------------------------------------------------
package spca_pkg;

  localparam int unsigned CfgW    = 25;
  localparam int unsigned LenW    = 32;
  localparam int unsigned AlignW  = 17;
  localparam int unsigned PageW   = 4;
  localparam int unsigned CountW  = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned OffW    = 24;
  localparam int unsigned ChunkW  = 25;

  localparam logic [CfgW-1:0] PageSizeReset = 25'd65536;
  localparam logic [CfgW-1:0] PageSizeMax   = 25'd16777216;

  typedef enum logic [1:0] {
    OP_CHUNK   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_RESET   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_GRANT   = 3'd0,
    ST_WAIT    = 3'd1,
    ST_RELEASE = 3'd2,
    ST_RESET   = 3'd3,
    ST_REFUSED = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]          opcode;
    logic [LenW-1:0]     request_length;
    logic [AlignW-1:0]   align_bytes;
    logic [PageW-1:0]    release_page;
    logic [CountW-1:0]   release_count;
  } in_item_t;

  typedef struct packed {
    logic [StatusW-1:0] result_status;
    logic [PageW-1:0]   chunk_page;
    logic [OffW-1:0]    chunk_offset;
    logic [ChunkW-1:0]  chunk_length;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic scan_clear;   // restart the page scan
    logic scan_step;    // examine one page
    logic div_start;    // start the alignment division
    logic div_step;     // one quotient bit
    logic grant;        // commit the grant
    logic open_page;    // open a new page
    logic reclaim;      // clear all unreferenced pages
    logic release_refs; // apply a release
    logic pool_reset;   // clear fills and page count
    logic open_first;   // open page zero if none open
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic div_done;
    logic fits;
    logic all_open;
    logic any_free;
    logic any_refs;
  } sts_t;

endpackage

[hdl/spca_if.sv]
// ----------------------------------------------------------------------------
// spca_in_if / spca_out_if
// Valid/ready channels carrying one word each.
// ----------------------------------------------------------------------------
interface spca_in_if;
  logic               valid;
  logic               ready;
  spca_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface spca_out_if;
  logic                valid;
  logic                ready;
  spca_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/spca_datapath.sv]
// ----------------------------------------------------------------------------
// spca_datapath
// Page tables, sequential best-page scan and a restoring alignment divider.
// ----------------------------------------------------------------------------
module spca_datapath #(
  parameter int unsigned MaxPages = 16,
  parameter int unsigned RefBits  = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [spca_pkg::CfgW-1:0]       page_size_i,
  input  spca_pkg::in_item_t              item_i,
  input  spca_pkg::cmd_t                  cmd_i,
  output spca_pkg::sts_t                  sts_o,
  output logic [spca_pkg::PageW-1:0]      page_o,
  output logic [spca_pkg::OffW-1:0]       offset_o,
  output logic [spca_pkg::ChunkW-1:0]     length_o
);
  localparam int unsigned IdxW = (MaxPages > 1) ? $clog2(MaxPages) : 1;
  localparam int unsigned CntW = $clog2(MaxPages + 1);
  localparam int unsigned FW   = spca_pkg::CfgW;
  localparam int unsigned AW   = spca_pkg::AlignW;
  localparam int unsigned DivW = 5;
  localparam logic [RefBits-1:0] RefMax = '1;

  logic [FW-1:0]      fill_q [MaxPages];
  logic [RefBits-1:0] refs_q [MaxPages];
  logic [CntW-1:0]    in_use_q;
  logic [MaxPages-1:0] ref_nz;

  // Effective capacity.
  logic [FW-1:0] cap;
  always_comb begin
    if (page_size_i == '0) cap = FW'(1);
    else if (page_size_i > spca_pkg::PageSizeMax) cap = spca_pkg::PageSizeMax;
    else cap = page_size_i;
  end

  // Scan: one page per step.
  logic [CntW-1:0] scan_q;
  logic [IdxW-1:0] best_q;
  logic [FW-1:0]   best_free_q;
  logic [FW-1:0]   cur_fill, cur_free;
  assign cur_fill = fill_q[scan_q[IdxW-1:0]];
  assign cur_free = (cur_fill >= cap) ? '0 : cap - cur_fill;

  // Divider: q = (fill + a - 1) / a, one quotient bit a step.
  logic [AW-1:0]   align;
  logic [FW:0]     num_q;      // dividend shifting out
  logic [FW:0]     quo_q;
  logic [AW:0]     rem_q;
  logic [DivW-1:0] dcnt_q;
  logic [AW+1:0]   rem_sh;
  logic [FW+AW:0]  aligned;
  logic [FW+AW:0]  room;
  logic [FW+AW:0]  grant_len;
  assign align  = (item_i.align_bytes == '0) ? AW'(1) : item_i.align_bytes;
  assign rem_sh = {rem_q, num_q[FW]};
  assign aligned = (FW+AW+1)'(quo_q) * (FW+AW+1)'(align);
  assign room    = (FW+AW+1)'(cap) - aligned;
  assign grant_len = ((FW+AW+1)'(item_i.request_length) < room) ?
                     (FW+AW+1)'(item_i.request_length) : room;

  always_comb begin
    for (int i = 0; i < MaxPages; i++) ref_nz[i] = (refs_q[i] != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxPages; i++) begin
        fill_q[i] <= '0;
        refs_q[i] <= '0;
      end
      in_use_q    <= '0;
      scan_q      <= '0;
      best_q      <= '0;
      best_free_q <= '0;
      num_q       <= '0;
      quo_q       <= '0;
      rem_q       <= '0;
      dcnt_q      <= '0;
    end else begin
      if (cmd_i.open_first && in_use_q == '0) in_use_q <= CntW'(1);
      if (cmd_i.scan_clear) begin
        scan_q      <= '0;
        best_q      <= '0;
        best_free_q <= '0;
      end else if (cmd_i.scan_step) begin
        if (cur_free >= best_free_q) begin
          best_free_q <= cur_free;
          best_q      <= scan_q[IdxW-1:0];
        end
        scan_q <= scan_q + CntW'(1);
      end
      if (cmd_i.div_start) begin
        num_q  <= (FW+1)'(fill_q[best_q]) + (FW+1)'(align) - (FW+1)'(1);
        quo_q  <= '0;
        rem_q  <= '0;
        dcnt_q <= '0;
      end else if (cmd_i.div_step) begin
        num_q  <= {num_q[FW-1:0], 1'b0};
        dcnt_q <= dcnt_q + DivW'(1);
        if (rem_sh >= (AW+2)'(align)) begin
          rem_q <= (AW+1)'(rem_sh - (AW+2)'(align));
          quo_q <= {quo_q[FW-1:0], 1'b1};
        end else begin
          rem_q <= rem_sh[AW:0];
          quo_q <= {quo_q[FW-1:0], 1'b0};
        end
      end
      if (cmd_i.grant) begin
        fill_q[best_q] <= FW'(aligned + grant_len);
        if (refs_q[best_q] != RefMax) refs_q[best_q] <= refs_q[best_q] + RefBits'(1);
      end
      if (cmd_i.open_page) begin
        fill_q[in_use_q[IdxW-1:0]] <= '0;
        in_use_q <= in_use_q + CntW'(1);
      end
      if (cmd_i.reclaim) begin
        for (int i = 0; i < MaxPages; i++) if (!ref_nz[i]) fill_q[i] <= '0;
      end
      if (cmd_i.release_refs && 32'(item_i.release_page) < MaxPages) begin
        if (RefBits'(item_i.release_count) >= refs_q[item_i.release_page[IdxW-1:0]] ||
            (RefBits < spca_pkg::CountW &&
             (item_i.release_count >> RefBits) != '0))
          refs_q[item_i.release_page[IdxW-1:0]] <= '0;
        else
          refs_q[item_i.release_page[IdxW-1:0]] <=
            refs_q[item_i.release_page[IdxW-1:0]] - RefBits'(item_i.release_count);
      end
      if (cmd_i.pool_reset) begin
        for (int i = 0; i < MaxPages; i++) fill_q[i] <= '0;
        in_use_q <= '0;
      end
    end
  end

  assign sts_o.scan_done = (scan_q >= in_use_q);
  assign sts_o.div_done  = (dcnt_q == DivW'(FW + 1));
  assign sts_o.fits      = (aligned < (FW+AW+1)'(cap));
  assign sts_o.all_open  = (32'(in_use_q) >= MaxPages);
  assign sts_o.any_free  = (ref_nz != '1);
  assign sts_o.any_refs  = (ref_nz != '0);

  assign page_o   = spca_pkg::PageW'(best_q);
  assign offset_o = spca_pkg::OffW'(aligned);
  assign length_o = spca_pkg::ChunkW'(grant_len);
endmodule

[hdl/spca_ctrl.sv]
// ----------------------------------------------------------------------------
// spca_ctrl
// Sequencer for one operation at a time and the result register.
// ----------------------------------------------------------------------------
module spca_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  spca_in_if.sink                      in_ch,
  spca_out_if.source                   out_ch,
  output spca_pkg::in_item_t           item_o,
  output spca_pkg::cmd_t               cmd_o,
  input  spca_pkg::sts_t               sts_i,
  input  logic [spca_pkg::PageW-1:0]   page_i,
  input  logic [spca_pkg::OffW-1:0]    offset_i,
  input  logic [spca_pkg::ChunkW-1:0]  length_i
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DEC   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]          state_q, state_d;
  spca_pkg::in_item_t  item_q;
  spca_pkg::out_item_t res_q, res_d;
  logic                ovalid_q, ovalid_d;

  assign item_o       = item_q;
  assign in_ch.ready  = (state_q == S_IDLE) && !ovalid_q;
  assign out_ch.valid = ovalid_q;
  assign out_ch.data  = res_q;

  function automatic spca_pkg::out_item_t mk(input spca_pkg::status_e st);
    spca_pkg::out_item_t r;
    r = '0;
    r.result_status = st;
    return r;
  endfunction

  always_comb begin
    state_d  = state_q;
    res_d    = res_q;
    ovalid_d = ovalid_q && !out_ch.ready;
    cmd_o    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) state_d = S_DISP;
      end
      S_DISP: begin
        case (spca_pkg::op_e'(item_q.opcode))
          spca_pkg::OP_CHUNK: begin
            if (item_q.request_length == '0) begin
              res_d = mk(spca_pkg::ST_GRANT);
              state_d = S_OUT;
            end else begin
              cmd_o.open_first = 1'b1;
              cmd_o.scan_clear = 1'b1;
              state_d = S_SCAN;
            end
          end
          spca_pkg::OP_RELEASE: begin
            cmd_o.release_refs = 1'b1;
            res_d = mk(spca_pkg::ST_RELEASE);
            state_d = S_OUT;
          end
          spca_pkg::OP_RESET: begin
            if (sts_i.any_refs) res_d = mk(spca_pkg::ST_REFUSED);
            else begin
              cmd_o.pool_reset = 1'b1;
              res_d = mk(spca_pkg::ST_RESET);
            end
            state_d = S_OUT;
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (sts_i.scan_done) begin
          cmd_o.div_start = 1'b1;
          state_d = S_DIV;
        end else cmd_o.scan_step = 1'b1;
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_DEC;
        else cmd_o.div_step = 1'b1;
      end
      S_DEC: begin
        cmd_o.scan_clear = 1'b1;
        if (sts_i.fits) begin
          cmd_o.grant = 1'b1;
          res_d.result_status = spca_pkg::ST_GRANT;
          res_d.chunk_page    = page_i;
          res_d.chunk_offset  = offset_i;
          res_d.chunk_length  = length_i;
          state_d = S_OUT;
        end else if (!sts_i.all_open) begin
          cmd_o.open_page = 1'b1;
          state_d = S_SCAN;
        end else if (sts_i.any_free) begin
          cmd_o.reclaim = 1'b1;
          state_d = S_SCAN;
        end else begin
          res_d = mk(spca_pkg::ST_WAIT);
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        ovalid_d = 1'b1;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (in_ch.valid && in_ch.ready) item_q <= in_ch.data;
  end
endmodule

[hdl/staging_page_chunk_allocator_top.sv]
// Chunk request: each try runs the sequential page scan over the open pages
// and the 26-step alignment divider, then decides; up to two tries (open or
// reclaim, then grant). Release, pool reset and empty requests are decided
// at dispatch. One word is in flight at a time; the next is taken only once
// the result has been accepted. Reset clears all fills, references and the
// open page count; page_size returns to 65536.
// ----------------------------------------------------------------------------
// staging_page_chunk_allocator_top
// Paged bump allocator with reference counted reclaim.
// ----------------------------------------------------------------------------
module staging_page_chunk_allocator_top #(
  parameter int unsigned MaxPages = 16,
  parameter int unsigned RefBits  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [spca_pkg::CfgW-1:0]  cfg_wdata_i,
  spca_in_if.sink                    in_ch,
  spca_out_if.source                 out_ch
);
  logic [spca_pkg::CfgW-1:0]   page_size_q;
  spca_pkg::in_item_t          item;
  spca_pkg::cmd_t              cmd;
  spca_pkg::sts_t              sts;
  logic [spca_pkg::PageW-1:0]  page;
  logic [spca_pkg::OffW-1:0]   offset;
  logic [spca_pkg::ChunkW-1:0] length;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) page_size_q <= spca_pkg::PageSizeReset;
    else if (cfg_we_i) page_size_q <= cfg_wdata_i;
  end

  spca_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_ch, .out_ch,
    .item_o(item), .cmd_o(cmd), .sts_i(sts),
    .page_i(page), .offset_i(offset), .length_i(length)
  );

  spca_datapath #(.MaxPages(MaxPages), .RefBits(RefBits)) u_dp (
    .clk_i, .rst_ni, .page_size_i(page_size_q), .item_i(item),
    .cmd_i(cmd), .sts_o(sts), .page_o(page), .offset_o(offset), .length_o(length)
  );
endmodule
